// ----- sv/dafs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DRAM address field splitter package
// Shared types, constants and the field order table.
// ----------------------------------------------------------------------------
package dafs_pkg;

  localparam int PHYS_ADDR_W  = 40;
  localparam int ADDR_W_DEF   = 40;
  localparam int MAX_ROW_BITS = 18;
  localparam int MAX_COL_BITS = 12;
  localparam int MAX_CH_BITS  = 4;
  localparam int MAX_RK_BITS  = 4;
  localparam int MAX_BK_BITS  = 6;
  localparam int MAX_DROP     = 12;

  localparam int CHANNEL_W = 4;
  localparam int RANK_W    = 4;
  localparam int BANK_W    = 6;
  localparam int ROW_W     = 18;
  localparam int COLUMN_W  = 12;

  localparam int FIELD_VAL_W = (MAX_ROW_BITS > MAX_COL_BITS) ?
                               ((MAX_ROW_BITS > MAX_BK_BITS) ? MAX_ROW_BITS : MAX_BK_BITS) :
                               ((MAX_COL_BITS > MAX_BK_BITS) ? MAX_COL_BITS : MAX_BK_BITS);

  localparam int NUM_FIELDS = 5;
  localparam int NUM_ORDERS = 8;

  localparam int ORDER_W   = 3;
  localparam int DROP_W    = 4;
  localparam int CH_CFG_W  = 3;
  localparam int RK_CFG_W  = 3;
  localparam int BK_CFG_W  = 3;
  localparam int ROW_CFG_W = 5;
  localparam int COL_CFG_W = 4;
  localparam int WIDTH_SEL_W = 5;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_MAPPING_ORDER = 3'd0,
    REG_DROP_BITS     = 3'd1,
    REG_CHANNEL_WIDTH = 3'd2,
    REG_RANK_WIDTH    = 3'd3,
    REG_BANK_WIDTH    = 3'd4,
    REG_ROW_WIDTH     = 3'd5,
    REG_COLUMN_WIDTH  = 3'd6
  } reg_e;

  typedef enum logic [2:0] {
    FIELD_CHANNEL = 3'd0,
    FIELD_RANK    = 3'd1,
    FIELD_BANK    = 3'd2,
    FIELD_ROW     = 3'd3,
    FIELD_COLUMN  = 3'd4
  } field_e;

  localparam field_e ORDER_TABLE [NUM_ORDERS][NUM_FIELDS] = '{
    '{FIELD_BANK,    FIELD_COLUMN, FIELD_ROW,    FIELD_RANK,   FIELD_CHANNEL},
    '{FIELD_RANK,    FIELD_BANK,   FIELD_COLUMN, FIELD_ROW,    FIELD_CHANNEL},
    '{FIELD_ROW,     FIELD_COLUMN, FIELD_BANK,   FIELD_RANK,   FIELD_CHANNEL},
    '{FIELD_COLUMN,  FIELD_ROW,    FIELD_BANK,   FIELD_RANK,   FIELD_CHANNEL},
    '{FIELD_BANK,    FIELD_RANK,   FIELD_COLUMN, FIELD_ROW,    FIELD_CHANNEL},
    '{FIELD_COLUMN,  FIELD_RANK,   FIELD_BANK,   FIELD_ROW,    FIELD_CHANNEL},
    '{FIELD_CHANNEL, FIELD_BANK,   FIELD_RANK,   FIELD_COLUMN, FIELD_ROW},
    '{FIELD_CHANNEL, FIELD_BANK,   FIELD_COLUMN, FIELD_ROW,    FIELD_RANK}
  };

  typedef struct packed {
    logic [CH_CFG_W-1:0]  channel;
    logic [RK_CFG_W-1:0]  rank;
    logic [BK_CFG_W-1:0]  bank;
    logic [ROW_CFG_W-1:0] row;
    logic [COL_CFG_W-1:0] column;
  } widths_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic [RANK_W-1:0]    rank;
    logic [BANK_W-1:0]    bank;
    logic [ROW_W-1:0]     row;
    logic [COLUMN_W-1:0]  column;
    logic                 misaligned;
  } result_t;

endpackage
`default_nettype wire

// ----- sv/dafs_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Address input channel
// Valid/ready channel that carries one physical address per item.
// ----------------------------------------------------------------------------
interface dafs_in_if;
  import dafs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [PHYS_ADDR_W-1:0] phys_address;

  modport source (output valid, output phys_address, input ready);
  modport sink (input valid, input phys_address, output ready);
endinterface
`default_nettype wire

// ----- sv/dafs_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Split address output channel
// Valid/ready channel that carries the DRAM coordinates of one address.
// ----------------------------------------------------------------------------
interface dafs_out_if;
  import dafs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CHANNEL_W-1:0] channel;
  logic [RANK_W-1:0]    rank;
  logic [BANK_W-1:0]    bank;
  logic [ROW_W-1:0]     row;
  logic [COLUMN_W-1:0]  column;
  logic                 misaligned;

  modport source (output valid, output channel, output rank, output bank, output row,
                  output column, output misaligned, input ready);
  modport sink (input valid, input channel, input rank, input bank, input row,
                input column, input misaligned, output ready);
endinterface
`default_nettype wire

// ----- sv/dafs_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Field extraction stage
// Takes one field off the low end of the remaining address and registers it.
// ----------------------------------------------------------------------------
module dafs_stage #(
  parameter int ADDR_WIDTH = dafs_pkg::ADDR_W_DEF,
  parameter int STAGE_IDX  = 0
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire  [dafs_pkg::ORDER_W-1:0]        order_i,
  input  wire  dafs_pkg::widths_t             widths_i,
  input  wire                                 valid_i,
  output logic                                ready_o,
  input  wire  [ADDR_WIDTH-1:0]               addr_i,
  input  wire  dafs_pkg::result_t             res_i,
  output logic                                valid_o,
  input  wire                                 ready_i,
  output logic [ADDR_WIDTH-1:0]               addr_o,
  output dafs_pkg::result_t                   res_o
);
  import dafs_pkg::*;

  field_e                            fld;
  logic [WIDTH_SEL_W-1:0]            width;
  logic [ADDR_WIDTH+FIELD_VAL_W-1:0] ext;
  logic [FIELD_VAL_W-1:0]            val;
  logic [ADDR_WIDTH-1:0]             addr_d;
  result_t                           res_d;
  logic                              valid_q;
  logic [ADDR_WIDTH-1:0]             addr_q;
  result_t                           res_q;

  assign fld = ORDER_TABLE[order_i][STAGE_IDX];
  assign ext = {{FIELD_VAL_W{1'b0}}, addr_i};

  always_comb begin
    case (fld)
      FIELD_CHANNEL: width = WIDTH_SEL_W'(widths_i.channel);
      FIELD_RANK:    width = WIDTH_SEL_W'(widths_i.rank);
      FIELD_BANK:    width = WIDTH_SEL_W'(widths_i.bank);
      FIELD_ROW:     width = WIDTH_SEL_W'(widths_i.row);
      FIELD_COLUMN:  width = WIDTH_SEL_W'(widths_i.column);
      default:       width = '0;
    endcase

    for (int j = 0; j < FIELD_VAL_W; j++) begin
      val[j] = ext[j] & (j < int'(width));
    end
    addr_d = addr_i >> width;

    res_d = res_i;
    case (fld)
      FIELD_CHANNEL: res_d.channel = val[CHANNEL_W-1:0];
      FIELD_RANK:    res_d.rank    = val[RANK_W-1:0];
      FIELD_BANK:    res_d.bank    = val[BANK_W-1:0];
      FIELD_ROW:     res_d.row     = val[ROW_W-1:0];
      FIELD_COLUMN:  res_d.column  = val[COLUMN_W-1:0];
      default:       res_d = res_i;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      addr_q <= addr_d;
      res_q  <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign addr_o  = addr_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

// ----- sv/dram_address_field_splitter_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DRAM address field splitter
// Splits a byte physical address into channel, rank, bank, row and column.
// ----------------------------------------------------------------------------
// The block takes one address per cycle while the output does not stall
// and returns its split: one register stage drops the transaction offset
// and flags a misaligned address, then five stages each take one field off
// the low end in the order that the mapping order register selects.
// A stall at the output holds every stage that is full, and ready reaches
// the input through the chain of stage registers in the same cycle.
// ----------------------------------------------------------------------------
module dram_address_field_splitter_unit #(
  parameter int ADDR_WIDTH = dafs_pkg::ADDR_W_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  dafs_in_if.sink                        req_i,
  dafs_out_if.source                     rsp_o,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [dafs_pkg::PADDR_W-1:0]   paddr,
  input  wire  [dafs_pkg::PDATA_W-1:0]   pwdata,
  output logic [dafs_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import dafs_pkg::*;

  logic [ORDER_W-1:0]   order_q;
  logic [DROP_W-1:0]    drop_q;
  logic [CH_CFG_W-1:0]  ch_w_q;
  logic [RK_CFG_W-1:0]  rk_w_q;
  logic [BK_CFG_W-1:0]  bk_w_q;
  logic [ROW_CFG_W-1:0] row_w_q;
  logic [COL_CFG_W-1:0] col_w_q;
  reg_e                 reg_idx;
  logic                 cfg_wr;
  logic [DROP_W-1:0]    drop;
  widths_t              widths;

  logic [ADDR_WIDTH+PHYS_ADDR_W-1:0] in_ext;
  logic [ADDR_WIDTH-1:0]             in_addr;
  logic                              in_mis;

  logic                  vld [NUM_FIELDS+1];
  logic                  rdy [NUM_FIELDS+1];
  logic [ADDR_WIDTH-1:0] addr [NUM_FIELDS+1];
  result_t               res [NUM_FIELDS+1];
  logic                  s0_valid_q;
  logic [ADDR_WIDTH-1:0] s0_addr_q;
  logic                  s0_mis_q;

  // Configuration port.
  assign reg_idx = reg_e'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_W'(0);
      drop_q  <= DROP_W'(6);
      ch_w_q  <= CH_CFG_W'(0);
      rk_w_q  <= RK_CFG_W'(1);
      bk_w_q  <= BK_CFG_W'(4);
      row_w_q <= ROW_CFG_W'(14);
      col_w_q <= COL_CFG_W'(7);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MAPPING_ORDER: order_q <= pwdata[ORDER_W-1:0];
        REG_DROP_BITS:     drop_q  <= pwdata[DROP_W-1:0];
        REG_CHANNEL_WIDTH: ch_w_q  <= pwdata[CH_CFG_W-1:0];
        REG_RANK_WIDTH:    rk_w_q  <= pwdata[RK_CFG_W-1:0];
        REG_BANK_WIDTH:    bk_w_q  <= pwdata[BK_CFG_W-1:0];
        REG_ROW_WIDTH:     row_w_q <= pwdata[ROW_CFG_W-1:0];
        REG_COLUMN_WIDTH:  col_w_q <= pwdata[COL_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAPPING_ORDER: prdata = PDATA_W'(order_q);
      REG_DROP_BITS:     prdata = PDATA_W'(drop_q);
      REG_CHANNEL_WIDTH: prdata = PDATA_W'(ch_w_q);
      REG_RANK_WIDTH:    prdata = PDATA_W'(rk_w_q);
      REG_BANK_WIDTH:    prdata = PDATA_W'(bk_w_q);
      REG_ROW_WIDTH:     prdata = PDATA_W'(row_w_q);
      REG_COLUMN_WIDTH:  prdata = PDATA_W'(col_w_q);
      default:           prdata = '0;
    endcase
  end

  // Widths above their range act as their maximum.
  always_comb begin
    drop           = (int'(drop_q) > MAX_DROP) ? DROP_W'(MAX_DROP) : drop_q;
    widths.channel = (int'(ch_w_q) > MAX_CH_BITS) ? CH_CFG_W'(MAX_CH_BITS) : ch_w_q;
    widths.rank    = (int'(rk_w_q) > MAX_RK_BITS) ? RK_CFG_W'(MAX_RK_BITS) : rk_w_q;
    widths.bank    = (int'(bk_w_q) > MAX_BK_BITS) ? BK_CFG_W'(MAX_BK_BITS) : bk_w_q;
    widths.row     = (int'(row_w_q) > MAX_ROW_BITS) ? ROW_CFG_W'(MAX_ROW_BITS) : row_w_q;
    widths.column  = (int'(col_w_q) > MAX_COL_BITS) ? COL_CFG_W'(MAX_COL_BITS) : col_w_q;
  end

  // Offset drop stage.
  assign in_ext  = {{ADDR_WIDTH{1'b0}}, req_i.phys_address};
  assign in_addr = in_ext[ADDR_WIDTH-1:0];

  always_comb begin
    in_mis = 1'b0;
    for (int j = 0; j < ADDR_WIDTH; j++) begin
      in_mis = in_mis | (in_addr[j] & (j < int'(drop)));
    end
  end

  assign req_i.ready = !s0_valid_q || rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s0_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s0_addr_q <= in_addr >> drop;
      s0_mis_q  <= in_mis;
    end
  end

  always_comb begin
    vld[0]            = s0_valid_q;
    addr[0]           = s0_addr_q;
    res[0]            = '0;
    res[0].misaligned = s0_mis_q;
  end

  // Field extraction stages.
  for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_stage
    dafs_stage #(
      .ADDR_WIDTH (ADDR_WIDTH),
      .STAGE_IDX  (k)
    ) u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .order_i  (order_q),
      .widths_i (widths),
      .valid_i  (vld[k]),
      .ready_o  (rdy[k]),
      .addr_i   (addr[k]),
      .res_i    (res[k]),
      .valid_o  (vld[k+1]),
      .ready_i  (rdy[k+1]),
      .addr_o   (addr[k+1]),
      .res_o    (res[k+1])
    );
  end

  assign rdy[NUM_FIELDS]  = rsp_o.ready;
  assign rsp_o.valid      = vld[NUM_FIELDS];
  assign rsp_o.channel    = res[NUM_FIELDS].channel;
  assign rsp_o.rank       = res[NUM_FIELDS].rank;
  assign rsp_o.bank       = res[NUM_FIELDS].bank;
  assign rsp_o.row        = res[NUM_FIELDS].row;
  assign rsp_o.column     = res[NUM_FIELDS].column;
  assign rsp_o.misaligned = res[NUM_FIELDS].misaligned;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DRAM address field splitter testbench
// Streams physical addresses through the splitter under many register
// settings and idling patterns, predicts each split with a local model of
// the field peeling, and compares every returned item field by field.
// ----------------------------------------------------------------------------
module tb;
  import dafs_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int PIPE_SLACK     = 20;
  localparam int RANDOM_SETS    = 34;
  localparam int ITEMS_PER_SET  = 45;
  localparam int MAX_REPORTS    = 20;

  localparam int REG_BITS [7] = '{ORDER_W, DROP_W, CH_CFG_W, RK_CFG_W, BK_CFG_W,
                                  ROW_CFG_W, COL_CFG_W};
  localparam int REG_HIGH [7] = '{NUM_ORDERS - 1, MAX_DROP, MAX_CH_BITS, MAX_RK_BITS,
                                  MAX_BK_BITS, MAX_ROW_BITS, MAX_COL_BITS};

  localparam field_e PEEL_ORDER [NUM_ORDERS][NUM_FIELDS] = '{
    '{FIELD_BANK,    FIELD_COLUMN, FIELD_ROW,    FIELD_RANK,   FIELD_CHANNEL},
    '{FIELD_RANK,    FIELD_BANK,   FIELD_COLUMN, FIELD_ROW,    FIELD_CHANNEL},
    '{FIELD_ROW,     FIELD_COLUMN, FIELD_BANK,   FIELD_RANK,   FIELD_CHANNEL},
    '{FIELD_COLUMN,  FIELD_ROW,    FIELD_BANK,   FIELD_RANK,   FIELD_CHANNEL},
    '{FIELD_BANK,    FIELD_RANK,   FIELD_COLUMN, FIELD_ROW,    FIELD_CHANNEL},
    '{FIELD_COLUMN,  FIELD_RANK,   FIELD_BANK,   FIELD_ROW,    FIELD_CHANNEL},
    '{FIELD_CHANNEL, FIELD_BANK,   FIELD_RANK,   FIELD_COLUMN, FIELD_ROW},
    '{FIELD_CHANNEL, FIELD_BANK,   FIELD_COLUMN, FIELD_ROW,    FIELD_RANK}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  dafs_in_if  req_if ();
  dafs_out_if rsp_if ();

  dram_address_field_splitter_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [31:0]            cfg_reg [7] = '{32'd0, 32'd6, 32'd0, 32'd1, 32'd4, 32'd14, 32'd7};
  logic [PHYS_ADDR_W-1:0] addr_q [$];
  result_t                split_q [$];
  int                     send_idle_pct = 0;
  int                     recv_stall_pct = 0;
  int                     n_accepted = 0;
  int                     n_checked = 0;
  int                     n_errors = 0;
  int                     n_settings = 0;
  int                     cycle_count = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int clamp_width(logic [31:0] v, int hi);
    return (v > hi) ? hi : int'(v);
  endfunction

  function automatic result_t split_address(logic [PHYS_ADDR_W-1:0] addr);
    logic [63:0] rest;
    logic [63:0] part [NUM_FIELDS];
    int          w [NUM_FIELDS];
    int          drop;
    int          ord;
    int          k;
    field_e      f;
    result_t     r;
    drop = clamp_width(cfg_reg[REG_DROP_BITS], MAX_DROP);
    ord = int'(cfg_reg[REG_MAPPING_ORDER] & 32'h7);
    w[FIELD_CHANNEL] = clamp_width(cfg_reg[REG_CHANNEL_WIDTH], MAX_CH_BITS);
    w[FIELD_RANK]    = clamp_width(cfg_reg[REG_RANK_WIDTH], MAX_RK_BITS);
    w[FIELD_BANK]    = clamp_width(cfg_reg[REG_BANK_WIDTH], MAX_BK_BITS);
    w[FIELD_ROW]     = clamp_width(cfg_reg[REG_ROW_WIDTH], MAX_ROW_BITS);
    w[FIELD_COLUMN]  = clamp_width(cfg_reg[REG_COLUMN_WIDTH], MAX_COL_BITS);
    rest = 64'(addr);
    r.misaligned = |(rest & ((64'd1 << drop) - 64'd1));
    rest = rest >> drop;
    for (k = 0; k < NUM_FIELDS; k++) begin
      f = PEEL_ORDER[ord][k];
      part[f] = rest & ((64'd1 << w[f]) - 64'd1);
      rest = rest >> w[f];
    end
    r.channel = part[FIELD_CHANNEL][CHANNEL_W-1:0];
    r.rank    = part[FIELD_RANK][RANK_W-1:0];
    r.bank    = part[FIELD_BANK][BANK_W-1:0];
    r.row     = part[FIELD_ROW][ROW_W-1:0];
    r.column  = part[FIELD_COLUMN][COLUMN_W-1:0];
    return r;
  endfunction

  task automatic write_reg(reg_e idx, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_reg[idx] = data & ((32'd1 << REG_BITS[idx]) - 32'd1);
  endtask

  task automatic config_all(logic [31:0] order, logic [31:0] drop, logic [31:0] ch,
                            logic [31:0] rk, logic [31:0] bk, logic [31:0] row,
                            logic [31:0] col);
    write_reg(REG_MAPPING_ORDER, order);
    write_reg(REG_DROP_BITS, drop);
    write_reg(REG_CHANNEL_WIDTH, ch);
    write_reg(REG_RANK_WIDTH, rk);
    write_reg(REG_BANK_WIDTH, bk);
    write_reg(REG_ROW_WIDTH, row);
    write_reg(REG_COLUMN_WIDTH, col);
    n_settings++;
  endtask

  task automatic drain_pipeline();
    while (addr_q.size() != 0 || req_if.valid || split_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        split_q.push_back(split_address(req_if.phys_address));
        n_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (addr_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_if.valid        <= 1'b1;
          req_if.phys_address <= addr_q.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (rsp_if.valid && rsp_if.ready) begin
        if (split_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected item ch %0d rk %0d bk %0d row %0d col %0d mis %0b",
                   $realtime, rsp_if.channel, rsp_if.rank, rsp_if.bank, rsp_if.row,
                   rsp_if.column, rsp_if.misaligned);
        end else begin
          want = split_q.pop_front();
          n_checked++;
          if (rsp_if.channel !== want.channel || rsp_if.rank !== want.rank ||
              rsp_if.bank !== want.bank || rsp_if.row !== want.row ||
              rsp_if.column !== want.column || rsp_if.misaligned !== want.misaligned) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS) begin
              $display("%0t: mismatch expected ch %0d rk %0d bk %0d row %0d col %0d mis %0b",
                       $realtime, want.channel, want.rank, want.bank, want.row,
                       want.column, want.misaligned);
              $display("%0t:          actual   ch %0d rk %0d bk %0d row %0d col %0d mis %0b",
                       $realtime, rsp_if.channel, rsp_if.rank, rsp_if.bank, rsp_if.row,
                       rsp_if.column, rsp_if.misaligned);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [31:0]            vals [7];
    logic [PHYS_ADDR_W-1:0] addr;
    int                     s;
    int                     i;
    int                     n;
    int                     drop_now;
    req_if.valid        = 1'b0;
    req_if.phys_address = '0;
    rsp_if.ready        = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings first, then every order, then the width extremes.
    addr_q.push_back(40'h00_0000_0000);
    addr_q.push_back(40'hFF_FFFF_FFFF);
    addr_q.push_back(40'h00_0000_0040);
    addr_q.push_back(40'h00_0000_0001);
    addr_q.push_back(40'hAA_AAAA_AAAA);
    addr_q.push_back(40'h55_5555_5555);
    addr_q.push_back(40'h80_0000_0000);
    addr_q.push_back(40'hFF_FFFF_FFC0);
    for (s = 0; s < NUM_ORDERS; s++) begin
      drain_pipeline();
      write_reg(REG_MAPPING_ORDER, s);
      addr_q.push_back(40'h5A_C3F0_9E40);
    end
    drain_pipeline();
    config_all(0, 0, 0, 0, 0, 0, 0);
    addr_q.push_back(40'hFF_FFFF_FFFF);
    addr_q.push_back(40'h00_0000_0001);
    drain_pipeline();
    config_all(7, 15, 7, 7, 7, 31, 15);
    addr_q.push_back(40'hFF_FFFF_FFFF);
    addr_q.push_back(40'h12_3456_789A);
    addr_q.push_back(40'h00_0000_1000);
    drain_pipeline();
    config_all(6, MAX_DROP, MAX_CH_BITS, MAX_RK_BITS, MAX_BK_BITS, MAX_ROW_BITS,
               MAX_COL_BITS);
    addr_q.push_back(40'hFF_FFFF_FFFF);
    addr_q.push_back(40'hAA_AAAA_A000);

    for (s = 0; s < RANDOM_SETS; s++) begin
      drain_pipeline();
      case ((s / 2) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      vals[0] = ($urandom() & ~32'h7) | (s % NUM_ORDERS);
      for (i = 1; i < 7; i++) begin
        vals[i] = $urandom();
        case ($urandom_range(0, 7))
          0: vals[i] = vals[i] & ~((32'd1 << REG_BITS[i]) - 32'd1);
          1: vals[i] = (vals[i] & ~((32'd1 << REG_BITS[i]) - 32'd1)) | REG_HIGH[i];
          2, 3: ;
          default: vals[i] = (vals[i] & ~((32'd1 << REG_BITS[i]) - 32'd1)) |
                             $urandom_range(0, REG_HIGH[i]);
        endcase
      end
      config_all(vals[0], vals[1], vals[2], vals[3], vals[4], vals[5], vals[6]);
      drop_now = clamp_width(cfg_reg[REG_DROP_BITS], MAX_DROP);
      for (n = 0; n < ITEMS_PER_SET; n++) begin
        addr = PHYS_ADDR_W'({$urandom(), $urandom()});
        case ($urandom_range(0, 3))
          0: ;
          1, 2: addr = addr & ~PHYS_ADDR_W'((64'd1 << drop_now) - 64'd1);
          default: addr = addr >> $urandom_range(0, PHYS_ADDR_W - 1);
        endcase
        addr_q.push_back(addr);
      end
    end

    drain_pipeline();
    $display("Split %0d addresses under %0d register settings, covering all field orders,",
             n_accepted, n_settings + 1);
    $display("width clamping and misalignment, with %0d items checked and %0d errors.",
             n_checked, n_errors);
    if (n_errors == 0 && split_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
